@@ design/rvbd_pkg.sv @@
// Shared types and constants for the rotate-vector-between-directions block.
package rvbd_pkg;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] from_z;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] to_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         case_kind;
  } out_t;

  localparam logic [1:0] KIND_GENERAL   = 2'd0;
  localparam logic [1:0] KIND_IDENTITY  = 2'd1;
  localparam logic [1:0] KIND_HALF_TURN = 2'd2;

  localparam logic [1:0] CFG_INPUTS_ARE_UNIT = 2'd0;
  localparam logic [1:0] CFG_PARALLEL_MARGIN = 2'd1;

  localparam logic [24:0] MARGIN_RESET = 25'd2;

endpackage

@@ design/rvbd_sqrt_pipe.sv @@
// Pipelined floor square root, one result bit per stage, several lanes in lockstep.
module rvbd_sqrt_pipe #(
  parameter int W     = 62,
  parameter int LANES = 3,
  parameter int PW    = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [LANES-1:0][W-1:0]       rad,
  input  logic [PW-1:0]                 in_pay,
  output logic                          out_vld,
  output logic [LANES-1:0][W/2-1:0]     root,
  output logic [PW-1:0]                 out_pay
);

  localparam int N = W / 2;

  logic                      vld [N+1];
  logic [PW-1:0]             pay [N+1];
  logic [LANES-1:0][W-1:0]   rem [N+1];
  logic [LANES-1:0][N-1:0]   rt  [N+1];

  assign vld[0] = in_vld;
  assign pay[0] = in_pay;
  assign rem[0] = rad;
  assign rt[0]  = '0;

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int B = N - 1 - g;
    logic [LANES-1:0][W-1:0] rem_next;
    logic [LANES-1:0][N-1:0] rt_next;
    logic [W:0]              trial [LANES];

    // candidate bit B: (2r + 2^B) * 2^B
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = ((W+1)'(rt[g][l]) << (B + 1)) | ((W+1)'(1) << (2 * B));
        if ({1'b0, rem[g][l]} >= trial[l]) begin
          rem_next[l] = W'({1'b0, rem[g][l]} - trial[l]);
          rt_next[l]  = rt[g][l] | (N'(1) << B);
        end else begin
          rem_next[l] = rem[g][l];
          rt_next[l]  = rt[g][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= rem_next;
        rt[g+1]  <= rt_next;
        pay[g+1] <= pay[g];
      end
    end
  end

  assign out_vld = vld[N];
  assign root    = rt[N];
  assign out_pay = pay[N];

endmodule

@@ design/rvbd_div_pipe.sv @@
// Pipelined fraction divider floor(n*2^QW/d) saturated to 2^QW, one quotient bit per stage.
module rvbd_div_pipe #(
  parameter int W     = 62,
  parameter int LANES = 5,
  parameter int QW    = 24,
  parameter int PW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [LANES-1:0][W-1:0]    num,
  input  logic [LANES-1:0][W-1:0]    den,
  input  logic [PW-1:0]              in_pay,
  output logic                       out_vld,
  output logic [LANES-1:0][QW:0]     quo,
  output logic [PW-1:0]              out_pay
);

  logic                      vld [QW+1];
  logic [PW-1:0]             pay [QW+1];
  logic [LANES-1:0][W-1:0]   rem [QW+1];
  logic [LANES-1:0][W-1:0]   dv  [QW+1];
  logic [LANES-1:0][QW-1:0]  q   [QW+1];
  logic [LANES-1:0]          sat [QW+1];

  assign vld[0] = in_vld;
  assign pay[0] = in_pay;
  assign rem[0] = num;
  assign dv[0]  = den;
  assign q[0]   = '0;

  // n >= d saturates to one (covers a zero divisor)
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sat[0][l] = num[l] >= den[l];
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [LANES-1:0][W-1:0] rem_next;
    logic [LANES-1:0]        qbit;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if ({rem[g][l], 1'b0} >= {1'b0, dv[g][l]}) begin
          rem_next[l] = W'({rem[g][l], 1'b0} - {1'b0, dv[g][l]});
          qbit[l]     = 1'b1;
        end else begin
          rem_next[l] = W'({rem[g][l], 1'b0});
          qbit[l]     = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= rem_next;
        dv[g+1]  <= dv[g];
        sat[g+1] <= sat[g];
        pay[g+1] <= pay[g];
        for (int l = 0; l < LANES; l++) begin
          q[g+1][l] <= {q[g][l][QW-2:0], qbit[l]};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = sat[QW][l] ? {1'b1, {QW{1'b0}}} : {1'b0, q[QW][l]};
    end
  end

  assign out_vld = vld[QW];
  assign out_pay = pay[QW];

endmodule

@@ design/rotate_vector_between_directions.sv @@
// Top level: rotation carrying one direction onto another, applied to a vector.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transfer carries the
//   source direction, the target direction and the vector, all signed Q8.24.
//   Output channel (out_valid / out_stall / out_data): one transfer per input
//   transfer, in order, with the rotated vector (saturated) and case_kind.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   inputs_are_unit, index 1 is parallel_margin; cfg_ready is always high.
//   Write config only while the pipeline is empty.
// Timing:
//   Fully pipelined, 72 stages: one input transfer is taken every cycle
//   while no stalled result holds the pipe. The depth comes
//   from the 31-stage square root (norms and cross length) followed by the
//   24-stage divider (cosine, sine and unit axis), one bit per stage.
// Reset (rst, synchronous): empties the pipeline, margin = 2, unit mode off.
// Stall: while a result waits with out_stall high, every stage holds and
//   in_stall goes high; nothing is dropped or repeated.
module rotate_vector_between_directions
  import rvbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  // carried alongside the early stages
  typedef struct packed {
    logic signed [63:0] dot;
    logic [61:0]        la;
    logic [61:0]        lb;
    logic [2:0]         cneg;
    logic               czero;
    logic [2:0][31:0]   vec;
  } ca_t;

  // rides through the square root
  typedef struct packed {
    logic signed [63:0] dot;
    logic [2:0]         cneg;
    logic               czero;
    logic [5:0]         sh;
    logic [2:0][29:0]   cmr;
    logic [2:0][31:0]   vec;
  } sq_pay_t;

  // rides through the divider
  typedef struct packed {
    logic signed [63:0] dot;
    logic [61:0]        len;
    logic               den_zero;
    logic [2:0]         cneg;
    logic               czero;
    logic [2:0][31:0]   vec;
  } dv_pay_t;

  // ---------------------------------------------------------------- helpers
  // right shift that brings the largest cross magnitude below 2^30
  function automatic logic [5:0] shift_for(input logic [61:0] m);
    logic [6:0] bl;
    bl = '0;
    for (int i = 0; i < 62; i++) begin
      if (m[i]) bl = 7'(i + 1);
    end
    return (bl > 7'd30) ? 6'(bl - 7'd30) : 6'd0;
  endfunction

  // Q16.48 -> Q8.24, nearest, ties up
  function automatic logic signed [28:0] rnd_q48(input logic signed [52:0] x);
    return 29'((x + 53'sd8388608) >>> 24);
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [62:0] x);
    logic signed [63:0] t;
    t = (64'(x) + 64'sd8388608) >>> 24;
    if (t > 64'sd2147483647) return 32'sh7fffffff;
    if (t < -64'sd2147483648) return 32'sh80000000;
    return 32'(t);
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
    if (x == 32'sh80000000) return 32'sh7fffffff;
    return -x;
  endfunction

  // ---------------------------------------------------------------- config
  logic        unit;
  logic [24:0] margin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit   <= 1'b0;
      margin <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_INPUTS_ARE_UNIT: unit   <= cfg_data[0];
        CFG_PARALLEL_MARGIN: margin <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // one enable for the whole pipe; it holds only when a result is blocked
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic v1, v2, v3, v4, v5, v6, v7, v8, vq, v9, vd;
  logic v10, v11, v12, v13, v14, v15, v16;

  // ---------------------------------------------------------------- s1: input
  in_t r1;
  always_ff @(posedge clk) begin
    if (en) r1 <= in_data;
  end

  // ---------------------------------------------------------------- s2: products
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  assign a[0] = r1.from_x;
  assign a[1] = r1.from_y;
  assign a[2] = r1.from_z;
  assign b[0] = r1.to_x;
  assign b[1] = r1.to_y;
  assign b[2] = r1.to_z;

  logic signed [63:0] p2_ab [3][3];
  logic signed [63:0] p2_aa [3];
  logic signed [63:0] p2_bb [3];
  logic [2:0][31:0]   vec2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p2_ab[i][j] <= a[i] * b[j];
        end
        p2_aa[i] <= a[i] * a[i];
        p2_bb[i] <= b[i] * b[i];
      end
      vec2[0] <= r1.vec_x;
      vec2[1] <= r1.vec_y;
      vec2[2] <= r1.vec_z;
    end
  end

  // ---------------------------------------------------------------- s3: dot, cross, norms^2
  logic signed [63:0] dot3;
  logic signed [62:0] c3 [3];
  logic [61:0]        la3, lb3;
  logic [2:0][31:0]   vec3;

  always_ff @(posedge clk) begin
    if (en) begin
      dot3  <= (p2_ab[0][0] >>> 2) + (p2_ab[1][1] >>> 2) + (p2_ab[2][2] >>> 2);
      c3[0] <= 63'((p2_ab[1][2] >>> 2) - (p2_ab[2][1] >>> 2));
      c3[1] <= 63'((p2_ab[2][0] >>> 2) - (p2_ab[0][2] >>> 2));
      c3[2] <= 63'((p2_ab[0][1] >>> 2) - (p2_ab[1][0] >>> 2));
      la3   <= 62'((p2_aa[0] >>> 2) + (p2_aa[1] >>> 2) + (p2_aa[2] >>> 2));
      lb3   <= 62'((p2_bb[0] >>> 2) + (p2_bb[1] >>> 2) + (p2_bb[2] >>> 2));
      vec3  <= vec2;
    end
  end

  // ---------------------------------------------------------------- s4: cross magnitudes
  logic [61:0] cm4 [3];
  ca_t         cr4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cm4[i]     <= c3[i][62] ? 62'(-c3[i]) : 62'(c3[i]);
        cr4.cneg[i] <= c3[i][62];
      end
      cr4.czero <= (c3[0] == '0) && (c3[1] == '0) && (c3[2] == '0);
      cr4.dot   <= dot3;
      cr4.la    <= la3;
      cr4.lb    <= lb3;
      cr4.vec   <= vec3;
    end
  end

  // ---------------------------------------------------------------- s5: scale shift
  // the OR has the same top bit as the largest magnitude
  logic [61:0] cm5 [3];
  logic [5:0]  sh5;
  ca_t         cr5;

  always_ff @(posedge clk) begin
    if (en) begin
      sh5 <= shift_for(cm4[0] | cm4[1] | cm4[2]);
      cm5 <= cm4;
      cr5 <= cr4;
    end
  end

  // ---------------------------------------------------------------- s6: scaled cross
  logic [2:0][29:0] cmr6;
  logic [5:0]       sh6;
  ca_t              cr6;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cmr6[i] <= 30'(cm5[i] >> sh5);
      end
      sh6 <= sh5;
      cr6 <= cr5;
    end
  end

  // ---------------------------------------------------------------- s7: squares
  logic [59:0]      sq7 [3];
  logic [2:0][29:0] cmr7;
  logic [5:0]       sh7;
  ca_t              cr7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq7[i] <= cmr6[i] * cmr6[i];
      end
      cmr7 <= cmr6;
      sh7  <= sh6;
      cr7  <= cr6;
    end
  end

  // ---------------------------------------------------------------- s8: cross length^2
  logic [61:0]      s8;
  logic [2:0][29:0] cmr8;
  logic [5:0]       sh8;
  ca_t              cr8;

  always_ff @(posedge clk) begin
    if (en) begin
      s8   <= 62'(sq7[0]) + 62'(sq7[1]) + 62'(sq7[2]);
      cmr8 <= cmr7;
      sh8  <= sh7;
      cr8  <= cr7;
    end
  end

  // ---------------------------------------------------------------- square roots
  logic [2:0][61:0] rad8;
  logic [2:0][30:0] rootq;
  sq_pay_t          pay8, payq;

  assign rad8[0] = cr8.la;
  assign rad8[1] = cr8.lb;
  assign rad8[2] = s8;

  assign pay8.dot   = cr8.dot;
  assign pay8.cneg  = cr8.cneg;
  assign pay8.czero = cr8.czero;
  assign pay8.sh    = sh8;
  assign pay8.cmr   = cmr8;
  assign pay8.vec   = cr8.vec;

  rvbd_sqrt_pipe #(
    .W     (62),
    .LANES (3),
    .PW    ($bits(sq_pay_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v8),
    .rad     (rad8),
    .in_pay  (pay8),
    .out_vld (vq),
    .root    (rootq),
    .out_pay (payq)
  );

  // ---------------------------------------------------------------- s9: den, len, |dot|
  logic [61:0]        den9, len9, absdot9;
  logic               den0_9;
  logic [30:0]        nc9;
  logic [2:0][29:0]   cmr9;
  logic signed [63:0] dot9;
  logic [2:0]         cneg9;
  logic               czero9;
  logic [2:0][31:0]   vec9;

  always_ff @(posedge clk) begin
    if (en) begin
      den9    <= rootq[0] * rootq[1];
      den0_9  <= (rootq[0] == '0) || (rootq[1] == '0);
      len9    <= 62'(64'(rootq[2]) << payq.sh);
      absdot9 <= payq.dot[63] ? 62'(-payq.dot) : 62'(payq.dot);
      nc9     <= rootq[2];
      cmr9    <= payq.cmr;
      dot9    <= payq.dot;
      cneg9   <= payq.cneg;
      czero9  <= payq.czero;
      vec9    <= payq.vec;
    end
  end

  // ---------------------------------------------------------------- divisions
  // lane 0 cosine, lanes 1..3 unit axis, lane 4 sine
  logic [4:0][61:0] num9, dvs9;
  logic [4:0][24:0] quo;
  dv_pay_t          payd9, payd;

  assign num9[0] = absdot9;
  assign num9[1] = 62'(cmr9[0]);
  assign num9[2] = 62'(cmr9[1]);
  assign num9[3] = 62'(cmr9[2]);
  assign num9[4] = len9;
  assign dvs9[0] = den9;
  assign dvs9[1] = 62'(nc9);
  assign dvs9[2] = 62'(nc9);
  assign dvs9[3] = 62'(nc9);
  assign dvs9[4] = den9;

  assign payd9.dot      = dot9;
  assign payd9.len      = len9;
  assign payd9.den_zero = den0_9;
  assign payd9.cneg     = cneg9;
  assign payd9.czero    = czero9;
  assign payd9.vec      = vec9;

  rvbd_div_pipe #(
    .W     (62),
    .LANES (5),
    .QW    (24),
    .PW    ($bits(dv_pay_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (v9),
    .num     (num9),
    .den     (dvs9),
    .in_pay  (payd9),
    .out_vld (vd),
    .quo     (quo),
    .out_pay (payd)
  );

  // ---------------------------------------------------------------- s10: cos, sin, axis
  // unit mode cosine is left unclamped for the case tests
  logic signed [41:0] cosv10;
  logic [24:0]        sin10;
  logic signed [25:0] u10 [3];
  logic               czero10;
  logic [2:0][31:0]   vec10;
  logic [39:0]        len_sh;

  assign len_sh = 40'(payd.len >> 22);

  always_ff @(posedge clk) begin
    if (en) begin
      if (unit) begin
        cosv10 <= 42'(payd.dot >>> 22);
        sin10  <= (len_sh > 40'd16777216) ? 25'd16777216 : 25'(len_sh);
      end else begin
        if (payd.den_zero) begin
          cosv10 <= '0;
        end else if (payd.dot[63]) begin
          cosv10 <= -$signed(42'(quo[0]));
        end else begin
          cosv10 <= $signed(42'(quo[0]));
        end
        sin10 <= quo[4];
      end
      for (int i = 0; i < 3; i++) begin
        u10[i] <= payd.cneg[i] ? -$signed({1'b0, quo[i+1]}) : $signed({1'b0, quo[i+1]});
      end
      czero10 <= payd.czero;
      vec10   <= payd.vec;
    end
  end

  // ---------------------------------------------------------------- s11: case, u*u, sin*u
  logic signed [26:0] thr;
  logic [1:0]         kind_next;

  assign thr = 27'sd16777216 - $signed({2'b0, margin});

  always_comb begin
    if (cosv10 > thr) begin
      kind_next = KIND_IDENTITY;
    end else if (cosv10 < -thr) begin
      kind_next = KIND_HALF_TURN;
    end else if (czero10) begin
      kind_next = (cosv10 > 42'sd0) ? KIND_IDENTITY : KIND_HALF_TURN;
    end else begin
      kind_next = KIND_GENERAL;
    end
  end

  // uu order: 00, 11, 22, 01, 02, 12
  logic signed [51:0] uu11 [6];
  logic signed [51:0] su11 [3];
  logic signed [25:0] cos11;
  logic signed [26:0] k11;
  logic [1:0]         kind11;
  logic [2:0][31:0]   vec11;

  always_ff @(posedge clk) begin
    if (en) begin
      uu11[0] <= u10[0] * u10[0];
      uu11[1] <= u10[1] * u10[1];
      uu11[2] <= u10[2] * u10[2];
      uu11[3] <= u10[0] * u10[1];
      uu11[4] <= u10[0] * u10[2];
      uu11[5] <= u10[1] * u10[2];
      for (int i = 0; i < 3; i++) begin
        su11[i] <= $signed({1'b0, sin10}) * u10[i];
      end
      // only the general case uses these, where |cos| <= 1
      cos11  <= $signed(cosv10[25:0]);
      k11    <= 27'sd16777216 - 27'($signed(cosv10[25:0]));
      kind11 <= kind_next;
      vec11  <= vec10;
    end
  end

  // ---------------------------------------------------------------- s12: round
  logic signed [25:0] w12  [6];
  logic signed [25:0] rs12 [3];
  logic signed [25:0] cos12;
  logic signed [26:0] k12;
  logic [1:0]         kind12;
  logic [2:0][31:0]   vec12;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 6; p++) begin
        w12[p] <= 26'(rnd_q48(53'(uu11[p])));
      end
      for (int i = 0; i < 3; i++) begin
        rs12[i] <= 26'(rnd_q48(53'(su11[i])));
      end
      cos12  <= cos11;
      k12    <= k11;
      kind12 <= kind11;
      vec12  <= vec11;
    end
  end

  // ---------------------------------------------------------------- s13: (1-cos)*u*u
  logic signed [52:0] kw13 [6];
  logic signed [25:0] rs13 [3];
  logic signed [25:0] cos13;
  logic [1:0]         kind13;
  logic [2:0][31:0]   vec13;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 6; p++) begin
        kw13[p] <= k12 * w12[p];
      end
      rs13   <= rs12;
      cos13  <= cos12;
      kind13 <= kind12;
      vec13  <= vec12;
    end
  end

  // ---------------------------------------------------------------- s14: matrix
  logic signed [28:0] rk [6];
  logic signed [28:0] m14 [3][3];
  logic [1:0]         kind14;
  logic [2:0][31:0]   vec14;

  always_comb begin
    for (int p = 0; p < 6; p++) begin
      rk[p] = rnd_q48(kw13[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m14[0][0] <= rk[0] + 29'(cos13);
      m14[1][1] <= rk[1] + 29'(cos13);
      m14[2][2] <= rk[2] + 29'(cos13);
      m14[0][1] <= rk[3] - 29'(rs13[2]);
      m14[1][0] <= rk[3] + 29'(rs13[2]);
      m14[0][2] <= rk[4] + 29'(rs13[1]);
      m14[2][0] <= rk[4] - 29'(rs13[1]);
      m14[1][2] <= rk[5] - 29'(rs13[0]);
      m14[2][1] <= rk[5] + 29'(rs13[0]);
      kind14    <= kind13;
      vec14     <= vec13;
    end
  end

  // ---------------------------------------------------------------- s15: M*v terms
  logic signed [60:0] mv15 [3][3];
  logic [1:0]         kind15;
  logic [2:0][31:0]   vec15;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv15[i][j] <= m14[i][j] * $signed(vec14[j]);
        end
      end
      kind15 <= kind14;
      vec15  <= vec14;
    end
  end

  // ---------------------------------------------------------------- s16: row sums
  logic signed [62:0] row16 [3];
  logic [1:0]         kind16;
  logic [2:0][31:0]   vec16;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        row16[i] <= 63'(mv15[i][0]) + 63'(mv15[i][1]) + 63'(mv15[i][2]);
      end
      kind16 <= kind15;
      vec16  <= vec15;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.case_kind <= kind16;
      case (kind16)
        KIND_IDENTITY: begin
          out_data.out_x <= $signed(vec16[0]);
          out_data.out_y <= $signed(vec16[1]);
          out_data.out_z <= $signed(vec16[2]);
        end
        KIND_HALF_TURN: begin
          out_data.out_x <= $signed(vec16[0]);
          out_data.out_y <= neg_sat($signed(vec16[1]));
          out_data.out_z <= neg_sat($signed(vec16[2]));
        end
        default: begin
          out_data.out_x <= rnd_sat(row16[0]);
          out_data.out_y <= rnd_sat(row16[1]);
          out_data.out_z <= rnd_sat(row16[2]);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
      v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
      v13 <= 1'b0; v14 <= 1'b0; v15 <= 1'b0; v16 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= v7;
      v9  <= vq;
      v10 <= vd;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      v15 <= v14;
      v16 <= v15;
      out_valid <= v16;
    end
  end

endmodule
